/* rtl/core/kped_pkg.sv */
// ----------------------------------------------------------------------------
// kped_pkg
// Shared types, codes and key map for the keypad event decoder.
// ----------------------------------------------------------------------------
package kped_pkg;

    // Time stamp width used for deadlines and compares
    localparam int TIME_W     = 32;
    // Port widths
    localparam int NOW_W      = 32;
    localparam int CODE_W     = 8;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int KEY_W      = 6;
    localparam int N_DIR      = 4;
    localparam int DIR_W      = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] REPEAT_START_RST  = 16'd350;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd150;

    // Event code ranges
    localparam logic [CODE_W-1:0] CODE_REL_LO = 8'd1;
    localparam logic [CODE_W-1:0] CODE_REL_HI = 8'd35;
    localparam logic [CODE_W-1:0] CODE_PRS_LO = 8'd129;
    localparam logic [CODE_W-1:0] CODE_PRS_HI = 8'd163;

    // Special characters in the key map
    localparam logic [CHAR_W-1:0] CH_FN    = 8'hff;
    localparam logic [CHAR_W-1:0] CH_SHIFT = 8'h81;
    localparam logic [CHAR_W-1:0] CH_ALT   = 8'h82;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_ENTER = 8'h28;
    localparam logic [CHAR_W-1:0] CH_NULL  = 8'h00;

    // Direction characters and their slots
    localparam logic [CHAR_W-1:0] CH_UP   = "w";
    localparam logic [CHAR_W-1:0] CH_DOWN = "s";
    localparam logic [CHAR_W-1:0] CH_PREV = "a";
    localparam logic [CHAR_W-1:0] CH_NEXT = "d";
    localparam logic [DIR_W-1:0]  DIR_UP   = 2'd0;
    localparam logic [DIR_W-1:0]  DIR_DOWN = 2'd1;
    localparam logic [DIR_W-1:0]  DIR_PREV = 2'd2;
    localparam logic [DIR_W-1:0]  DIR_NEXT = 2'd3;

    // One input item
    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] event_code;
        logic [NOW_W-1:0]  now_ms;
    } t_item;

    // One result item
    typedef struct packed {
        logic              key_valid;
        logic [CHAR_W-1:0] key_char;
        logic              is_delete;
        logic              is_enter;
        logic              up_pulse;
        logic              down_pulse;
        logic              prev_pulse;
        logic              next_pulse;
    } t_result;

    // One key map entry: plain, shifted, fn layer
    typedef struct packed {
        logic [CHAR_W-1:0] c_base;
        logic [CHAR_W-1:0] c_shift;
        logic [CHAR_W-1:0] c_fn;
    } t_key_entry;

    // Key map indexed by key number (row k/10, mirrored column folded in)
    function automatic t_key_entry key_entry(input logic [KEY_W-1:0] k);
        t_key_entry e;
        unique case (k)
            6'd0:  e = '{"p", "P", "@"};
            6'd1:  e = '{"o", "O", "+"};
            6'd2:  e = '{"i", "I", "-"};
            6'd3:  e = '{"u", "U", "_"};
            6'd4:  e = '{"y", "Y", ")"};
            6'd5:  e = '{"t", "T", "("};
            6'd6:  e = '{"r", "R", "3"};
            6'd7:  e = '{"e", "E", "2"};
            6'd8:  e = '{"w", "W", "1"};
            6'd9:  e = '{"q", "Q", "#"};
            6'd10: e = '{CH_DEL, CH_DEL, CH_DEL};
            6'd11: e = '{"l", "L", 8'h22};
            6'd12: e = '{"k", "K", 8'h27};
            6'd13: e = '{"j", "J", ";"};
            6'd14: e = '{"h", "H", ":"};
            6'd15: e = '{"g", "G", "/"};
            6'd16: e = '{"f", "F", "6"};
            6'd17: e = '{"d", "D", "5"};
            6'd18: e = '{"s", "S", "4"};
            6'd19: e = '{"a", "A", "*"};
            6'd20: e = '{CH_ENTER, CH_ENTER, CH_ENTER};
            6'd21: e = '{"$", "0", "0"};
            6'd22: e = '{"m", "M", "."};
            6'd23: e = '{"n", "N", ","};
            6'd24: e = '{"b", "B", "!"};
            6'd25: e = '{"v", "V", "?"};
            6'd26: e = '{"c", "C", "9"};
            6'd27: e = '{"x", "X", "8"};
            6'd28: e = '{"z", "Z", "7"};
            6'd29: e = '{CH_ALT, CH_ALT, CH_ALT};
            6'd30: e = '{CH_SHIFT, CH_SHIFT, CH_SHIFT};
            6'd31: e = '{CH_FN, CH_FN, CH_FN};
            6'd32: e = '{" ", " ", " "};
            6'd33: e = '{CH_NULL, CH_NULL, "0"};
            6'd34: e = '{CH_SHIFT, CH_SHIFT, CH_SHIFT};
            default: e = '{CH_NULL, CH_NULL, CH_NULL};
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/kped_in_stage.sv */
// ----------------------------------------------------------------------------
// kped_in_stage
// Input register: takes one request per cycle while not stalled and holds it for the decoder.
// ----------------------------------------------------------------------------
module kped_in_stage import kped_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [CODE_W-1:0] i_event_code,
    input  logic [NOW_W-1:0]  i_now_ms,
    input  logic              i_advance,
    output logic              o_vld,
    output t_item             o_item
);

    logic  r_vld;
    t_item r_item;

    // Stall only while a held request cannot move on
    assign o_in_stall = r_vld && !i_advance;

    // Hold valid, refill whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_vld <= i_in_valid;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= '{mode: i_mode, event_code: i_event_code, now_ms: i_now_ms};
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

/* rtl/core/kped_core.sv */
// ----------------------------------------------------------------------------
// kped_core
// Decoder and state: modifiers, held directions, repeat deadlines, registers.
// ----------------------------------------------------------------------------
module kped_core import kped_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_fire,
    input  t_item                i_item,
    output t_result              o_result
);

    logic [CFG_W-1:0]  r_start;
    logic [CFG_W-1:0]  r_period;
    logic              r_fn;
    logic              r_shift;
    logic              r_caps;
    logic [N_DIR-1:0]  r_held;
    logic [TIME_W-1:0] r_deadline [N_DIR];

    logic              n_fn;
    logic              n_shift;
    logic              n_caps;
    logic [N_DIR-1:0]  n_held;
    logic [TIME_W-1:0] n_deadline [N_DIR];
    logic [N_DIR-1:0]  pulse;
    t_result           res;

    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start_at;
    logic [TIME_W-1:0] period_at;
    logic              is_rel;
    logic              is_prs;
    logic [KEY_W-1:0]  key;
    t_key_entry        entry;
    logic [CHAR_W-1:0] ch;
    logic              dir_hit;
    logic [DIR_W-1:0]  dir;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= REPEAT_START_RST;
            r_period <= REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_START:  r_start  <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the code and look up the key
    always_comb begin
        now       = TIME_W'(i_item.now_ms);
        start_at  = now + TIME_W'(r_start);
        period_at = now + TIME_W'(r_period);
        is_rel    = (i_item.event_code >= CODE_REL_LO) && (i_item.event_code <= CODE_REL_HI);
        is_prs    = (i_item.event_code >= CODE_PRS_LO) && (i_item.event_code <= CODE_PRS_HI);
        key       = KEY_W'(i_item.event_code - (is_prs ? CODE_PRS_LO : CODE_REL_LO));
        entry     = key_entry(key);
        if (r_fn) begin
            ch = entry.c_fn;
        end else if (r_shift != r_caps) begin
            ch = entry.c_shift;
        end else begin
            ch = entry.c_base;
        end
        dir_hit = 1'b1;
        unique case (ch)
            CH_UP:   dir = DIR_UP;
            CH_DOWN: dir = DIR_DOWN;
            CH_PREV: dir = DIR_PREV;
            CH_NEXT: dir = DIR_NEXT;
            default: begin
                dir     = DIR_UP;
                dir_hit = 1'b0;
            end
        endcase
    end

    // Work out the result and the next state
    always_comb begin
        n_fn       = r_fn;
        n_shift    = r_shift;
        n_caps     = r_caps;
        n_held     = r_held;
        n_deadline = r_deadline;
        pulse      = '0;
        res        = '0;
        if (i_item.mode) begin
            // Tick: fire each held direction whose deadline has passed
            for (int i = 0; i < N_DIR; i++) begin
                if (r_held[i] && (now >= r_deadline[i])) begin
                    pulse[i]      = 1'b1;
                    n_deadline[i] = period_at;
                end
            end
        end else if (is_rel || is_prs) begin
            if (entry.c_base == CH_FN) begin
                n_fn = !r_fn;
            end else if (entry.c_base == CH_SHIFT) begin
                n_shift = is_prs;
                if (r_fn && is_prs) begin
                    n_caps = !r_caps;
                end
            end else if (ch == CH_NULL) begin
                // drop
            end else if (ch == CH_DEL) begin
                res.is_delete = is_prs;
            end else if (ch == CH_ENTER) begin
                res.is_enter = is_prs;
            end else begin
                if (dir_hit) begin
                    n_held[dir] = is_prs;
                    if (is_prs) begin
                        pulse[dir]      = 1'b1;
                        n_deadline[dir] = start_at;
                    end
                end
                if (is_prs) begin
                    res.key_valid = 1'b1;
                    res.key_char  = ch;
                end
            end
        end
        res.up_pulse   = pulse[DIR_UP];
        res.down_pulse = pulse[DIR_DOWN];
        res.prev_pulse = pulse[DIR_PREV];
        res.next_pulse = pulse[DIR_NEXT];
    end

    // Advance state when a request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn    <= 1'b0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_held  <= '0;
            for (int i = 0; i < N_DIR; i++) begin
                r_deadline[i] <= '0;
            end
        end else if (i_fire) begin
            r_fn       <= n_fn;
            r_shift    <= n_shift;
            r_caps     <= n_caps;
            r_held     <= n_held;
            r_deadline <= n_deadline;
        end
    end

    assign o_result = res;

endmodule

/* rtl/core/kped_out_stage.sv */
// ----------------------------------------------------------------------------
// kped_out_stage
// Result register: holds one decoded result until the consumer takes it.
// ----------------------------------------------------------------------------
module kped_out_stage import kped_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_result,
    output logic    o_advance,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic    r_vld;
    t_result r_result;

    // Move on when empty or when the consumer takes the result
    assign o_advance = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_advance) begin
            r_vld <= i_vld;
        end
    end

    // Load the result; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (o_advance && i_vld) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_vld;
    assign o_result    = r_result;

endmodule

/* rtl/core/keypad_event_decoder_with_repeat.sv */
// ----------------------------------------------------------------------------
// keypad_event_decoder_with_repeat
// Keypad event decoder with modifier state and typematic direction repeat.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. The block takes one request per
// clock cycle. An accepted request is held in the input register while the
// key map lookup and state update run combinationally into the result
// register, from which its result is shown on the result port. A stalled
// result holds the input register, which then stalls the request channel;
// with no output stall the rate is one item per cycle.
// Event requests (mode 0) decode press and release codes; tick requests
// (mode 1) check the held w/s/a/d directions against their deadlines using
// now_ms. Write the repeat registers only while no request is in flight.
// ----------------------------------------------------------------------------
module keypad_event_decoder_with_repeat import kped_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [CODE_W-1:0]    i_event_code,
    input  logic [NOW_W-1:0]     i_now_ms,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_key_valid,
    output logic [CHAR_W-1:0]    o_key_char,
    output logic                 o_is_delete,
    output logic                 o_is_enter,
    output logic                 o_up_pulse,
    output logic                 o_down_pulse,
    output logic                 o_prev_pulse,
    output logic                 o_next_pulse
);

    logic    s1_vld;
    t_item   s1_item;
    logic    advance;
    t_result core_result;
    t_result out_result;

    kped_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_event_code (i_event_code),
        .i_now_ms     (i_now_ms),
        .i_advance    (advance),
        .o_vld        (s1_vld),
        .o_item       (s1_item)
    );

    kped_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (s1_vld && advance),
        .i_item     (s1_item),
        .o_result   (core_result)
    );

    kped_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (s1_vld),
        .i_result    (core_result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    // Break out the result fields
    assign o_key_valid  = out_result.key_valid;
    assign o_key_char   = out_result.key_char;
    assign o_is_delete  = out_result.is_delete;
    assign o_is_enter   = out_result.is_enter;
    assign o_up_pulse   = out_result.up_pulse;
    assign o_down_pulse = out_result.down_pulse;
    assign o_prev_pulse = out_result.prev_pulse;
    assign o_next_pulse = out_result.next_pulse;

endmodule

/* rtl/core/kped_checker.sv */
// ----------------------------------------------------------------------------
// kped_checker
// Port-level checks for the keypad event decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kped_checker import kped_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_key_valid,
    input logic [CHAR_W-1:0] o_key_char,
    input logic              o_is_delete,
    input logic              o_is_enter,
    input logic              o_up_pulse,
    input logic              o_down_pulse,
    input logic              o_prev_pulse,
    input logic              o_next_pulse
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Character is zero unless a key was decoded
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_key_valid |-> o_key_char == '0)
        else $error("stray character");

    // Delete, enter and character are exclusive and carry no pulse
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_is_delete || o_is_enter) |->
            !o_key_valid && !(o_is_delete && o_is_enter) &&
            !(o_up_pulse || o_down_pulse || o_prev_pulse || o_next_pulse))
        else $error("delete or enter mixed with other output");

endmodule

bind keypad_event_decoder_with_repeat kped_checker u_kped_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_key_valid  (o_key_valid),
    .o_key_char   (o_key_char),
    .o_is_delete  (o_is_delete),
    .o_is_enter   (o_is_enter),
    .o_up_pulse   (o_up_pulse),
    .o_down_pulse (o_down_pulse),
    .o_prev_pulse (o_prev_pulse),
    .o_next_pulse (o_next_pulse)
);
